@@ rtl/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DESD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define DESD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define DESD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DESD_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/desd_pkg.sv @@
// Types and constants of the digitizer event stream deframer.
`default_nettype none

package desd_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [15:0] FINE_MASK = 16'h03ff;
  localparam logic [15:0] PROBE_BIT = 16'h8000;
  localparam logic [15:0] SEL_EXTENDED = 16'd2;

  // result kinds
  localparam logic [2:0] KIND_SUMMARY   = 3'd0;
  localparam logic [2:0] KIND_WAVE      = 3'd1;
  localparam logic [2:0] KIND_PROBE     = 3'd2;
  localparam logic [2:0] KIND_END       = 3'd3;
  localparam logic [2:0] KIND_MALFORMED = 3'd4;

  // event types
  localparam logic [1:0] EK_UNKNOWN = 2'd0;
  localparam logic [1:0] EK_DPP     = 2'd1;
  localparam logic [1:0] EK_WAVE    = 2'd2;

  typedef enum logic [20:0] {
    PH_H0    = 21'd1,
    PH_H1    = 21'd2,
    PH_H2    = 21'd4,
    PH_H3    = 21'd8,
    PH_H4    = 21'd16,
    PH_H5    = 21'd32,
    PH_H6    = 21'd64,
    PH_H7    = 21'd128,
    PH_SEL   = 21'd256,
    PH_XLO   = 21'd512,
    PH_XHI   = 21'd1024,
    PH_SQ    = 21'd2048,
    PH_LQ    = 21'd4096,
    PH_PU    = 21'd8192,
    PH_PROBE = 21'd16384,
    PH_NLO   = 21'd32768,
    PH_NHI   = 21'd65536,
    PH_SAMP  = 21'd131072,
    PH_PNLO  = 21'd262144,
    PH_PNHI  = 21'd524288,
    PH_PSAMP = 21'd1048576
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  channel;
    logic [1:0]  event_kind;
    logic [31:0] macro_number;
    logic [31:0] event_number;
    logic [31:0] coarse_time;
    logic [15:0] extended_time;
    logic [9:0]  fine_time;
    logic [15:0] short_charge;
    logic [15:0] long_charge;
    logic [15:0] sample_value;
    logic        last;
  } rec_t;

endpackage

`default_nettype wire

@@ rtl/desd_ifs.sv @@
// Stream interfaces of the deframer: input words and result records.
`default_nettype none

interface desd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] stream_word;

  modport source (output valid, output stream_word, input ready);
  modport sink (input valid, input stream_word, output ready);
endinterface

interface desd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  channel;
  logic [1:0]  event_kind;
  logic [31:0] macro_number;
  logic [31:0] event_number;
  logic [31:0] coarse_time;
  logic [15:0] extended_time;
  logic [9:0]  fine_time;
  logic [15:0] short_charge;
  logic [15:0] long_charge;
  logic [15:0] sample_value;
  logic        last;

  modport source (
    output valid, input ready,
    output kind, output channel, output event_kind, output macro_number,
    output event_number, output coarse_time, output extended_time, output fine_time,
    output short_charge, output long_charge, output sample_value, output last
  );
  modport sink (
    input valid, output ready,
    input kind, input channel, input event_kind, input macro_number,
    input event_number, input coarse_time, input extended_time, input fine_time,
    input short_charge, input long_charge, input sample_value, input last
  );
endinterface

`default_nettype wire

@@ rtl/desd_parser.sv @@
// Word-by-word event parser: phase register, field capture, counters, result record.
`default_nettype none
`include "assert_macros.svh"

module desd_parser import desd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [15:0] word,
  output logic        res_valid,
  output rec_t        res
);

  phase_t            phase, phase_next;
  logic [15:0]       low_half, low_half_next;
  logic [15:0]       samples_left, samples_left_next;
  logic              probe_flag, probe_flag_next;
  logic [15:0]       select_code, select_code_next;
  logic [2:0]        current_channel, current_channel_next;
  logic [1:0]        current_kind, current_kind_next;
  logic [31:0]       held_time, held_time_next;
  logic [15:0]       held_extended, held_extended_next;
  logic [9:0]        held_fine, held_fine_next;
  logic [15:0]       held_short, held_short_next;
  logic [15:0]       held_long, held_long_next;
  logic [31:0]       macro_counter, macro_counter_next;
  logic              chan_valid, chan_valid_next;
  logic [CH_W-1:0]   chan_index, chan_index_next;
  logic [31:0]       counters [NUM_CHANNELS];

  logic              finish;
  logic              emit;
  logic [2:0]        res_kind;
  logic [15:0]       res_sample;
  logic              res_last;
  logic [15:0]       dec_left;

  assign dec_left = samples_left - 16'd1;

  always_comb begin
    phase_next           = phase;
    low_half_next        = low_half;
    samples_left_next    = samples_left;
    probe_flag_next      = probe_flag;
    select_code_next     = select_code;
    current_channel_next = current_channel;
    current_kind_next    = current_kind;
    held_time_next       = held_time;
    held_extended_next   = held_extended;
    held_fine_next       = held_fine;
    held_short_next      = held_short;
    held_long_next       = held_long;
    macro_counter_next   = macro_counter;
    chan_valid_next      = chan_valid;
    chan_index_next      = chan_index;
    finish               = 1'b0;
    emit                 = 1'b0;
    res_kind             = KIND_SUMMARY;
    res_sample           = 16'd0;
    res_last             = 1'b0;

    case (phase)
      PH_H1: begin
        low_half_next = word;
        phase_next    = PH_H2;
      end
      PH_H2: begin
        low_half_next = word;
        phase_next    = PH_H3;
      end
      PH_H3: begin
        if (word == 16'd0 && (low_half == 16'(EK_DPP) || low_half == 16'(EK_WAVE))) begin
          current_kind_next = low_half[1:0];
        end else begin
          current_kind_next = EK_UNKNOWN;
        end
        phase_next = PH_H4;
      end
      PH_H4: begin
        low_half_next = word;
        phase_next    = PH_H5;
      end
      PH_H5: begin
        current_channel_next = low_half[2:0];
        chan_valid_next      = (word == 16'd0) && (low_half < 16'(NUM_CHANNELS));
        chan_index_next      = chan_valid_next ? low_half[CH_W-1:0] : '0;
        if (word == 16'd0 && low_half == 16'd0) begin
          macro_counter_next = macro_counter + 32'd1;
        end
        phase_next = PH_H6;
      end
      PH_H6: begin
        low_half_next = word;
        phase_next    = PH_H7;
      end
      PH_H7: begin
        held_time_next  = {word[14:0], low_half, 1'b0};
        probe_flag_next = 1'b0;
        if (current_kind == EK_UNKNOWN || !chan_valid) begin
          emit     = 1'b1;
          res_kind = KIND_MALFORMED;
          res_last = 1'b1;
          finish   = 1'b1;
        end else begin
          phase_next = (current_kind == EK_DPP) ? PH_SEL : PH_NLO;
        end
      end
      PH_SEL: begin
        select_code_next = word;
        phase_next       = PH_XLO;
      end
      PH_XLO: begin
        low_half_next = word;
        phase_next    = PH_XHI;
      end
      PH_XHI: begin
        if (select_code == SEL_EXTENDED) begin
          held_extended_next = word;
          held_fine_next     = low_half[9:0] & FINE_MASK[9:0];
        end
        phase_next = PH_SQ;
      end
      PH_SQ: begin
        held_short_next = word;
        phase_next      = PH_LQ;
      end
      PH_LQ: begin
        held_long_next = word;
        phase_next     = PH_PU;
      end
      PH_PU: begin
        phase_next = PH_PROBE;
      end
      PH_PROBE: begin
        probe_flag_next = (word & PROBE_BIT) != 16'd0;
        phase_next      = PH_NLO;
      end
      PH_NLO: begin
        low_half_next = word;
        phase_next    = PH_NHI;
      end
      PH_NHI: begin
        samples_left_next = low_half;
        emit              = 1'b1;
        res_kind          = KIND_SUMMARY;
        res_last          = (low_half == 16'd0) && !probe_flag;
        if (res_last) begin
          finish = 1'b1;
        end else begin
          phase_next = (low_half == 16'd0) ? PH_PNLO : PH_SAMP;
        end
      end
      PH_SAMP: begin
        samples_left_next = dec_left;
        emit              = 1'b1;
        res_kind          = KIND_WAVE;
        res_sample        = word;
        res_last          = (dec_left == 16'd0) && !probe_flag;
        if (res_last) begin
          finish = 1'b1;
        end else if (dec_left == 16'd0) begin
          phase_next = PH_PNLO;
        end
      end
      PH_PNLO: begin
        low_half_next = word;
        phase_next    = PH_PNHI;
      end
      PH_PNHI: begin
        samples_left_next = low_half;
        if (low_half == 16'd0) begin
          emit     = 1'b1;
          res_kind = KIND_END;
          res_last = 1'b1;
          finish   = 1'b1;
        end else begin
          phase_next = PH_PSAMP;
        end
      end
      PH_PSAMP: begin
        samples_left_next = dec_left;
        emit              = 1'b1;
        res_kind          = KIND_PROBE;
        res_sample        = word;
        res_last          = (dec_left == 16'd0);
        finish            = res_last;
      end
      default: begin
        // first header word, also recovers from any stray phase code
        low_half_next = word;
        phase_next    = PH_H1;
      end
    endcase

    if (finish) begin
      phase_next = PH_H0;
    end
  end

  always_comb begin
    res.kind          = res_kind;
    res.channel       = current_channel_next;
    res.event_kind    = current_kind_next;
    res.macro_number  = macro_counter_next;
    res.event_number  = chan_valid ? counters[chan_index] : 32'd0;
    res.coarse_time   = held_time_next;
    res.extended_time = held_extended_next;
    res.fine_time     = held_fine_next;
    res.short_charge  = held_short_next;
    res.long_charge   = held_long_next;
    res.sample_value  = res_sample;
    res.last          = res_last;
  end

  assign res_valid = step && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_H0;
      low_half        <= '0;
      samples_left    <= '0;
      probe_flag      <= 1'b0;
      select_code     <= '0;
      current_channel <= '0;
      current_kind    <= EK_UNKNOWN;
      held_time       <= '0;
      held_extended   <= '0;
      held_fine       <= '0;
      held_short      <= '0;
      held_long       <= '0;
      macro_counter   <= '1;
      chan_valid      <= 1'b0;
      chan_index      <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        counters[i] <= '0;
      end
    end else if (step) begin
      phase           <= phase_next;
      low_half        <= low_half_next;
      samples_left    <= samples_left_next;
      probe_flag      <= probe_flag_next;
      select_code     <= select_code_next;
      current_channel <= current_channel_next;
      current_kind    <= current_kind_next;
      held_time       <= held_time_next;
      held_extended   <= held_extended_next;
      held_fine       <= held_fine_next;
      held_short      <= held_short_next;
      held_long       <= held_long_next;
      macro_counter   <= macro_counter_next;
      chan_valid      <= chan_valid_next;
      chan_index      <= chan_index_next;
      if (finish && chan_valid) begin
        counters[chan_index] <= counters[chan_index] + 32'd1;
      end
    end
  end

  // an event's last transaction always returns the parser to the header
  `DESD_ASSERT_NXT(a_last_to_header, clk, rst, res_valid && res.last, phase == PH_H0)
  // bad channel never reports a per-channel count
  `DESD_ASSERT_IMP(a_bad_chan_zero, clk, rst, res_valid && !chan_valid,
                   res.event_number == 32'd0)

endmodule

`default_nettype wire

@@ rtl/desd_result_buf.sv @@
// Two-entry result buffer: output register plus skid register.
`default_nettype none
`include "assert_macros.svh"

module desd_result_buf import desd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output rec_t out_rec
);

  logic main_valid;
  logic skid_valid;
  rec_t main_rec;
  rec_t skid_rec;
  logic pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_rec   = main_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_valid <= push;
        end
      end else if (push) begin
        if (!main_valid) begin
          main_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_rec <= skid_valid ? skid_rec : push_rec;
    end else if (push && !main_valid) begin
      main_rec <= push_rec;
    end
    if (push && main_valid && !pop) begin
      skid_rec <= push_rec;
    end
  end

  `DESD_ASSERT_IMP(a_skid_behind_main, clk, rst, skid_valid, main_valid)
  `DESD_ASSERT_NXT(a_stall_fills_skid, clk, rst, push && main_valid && !pop, skid_valid)
  `DESD_ASSERT_NXT(a_skid_drains, clk, rst, pop && skid_valid, main_valid && !skid_valid)

endmodule

`default_nettype wire

@@ rtl/digitizer_event_stream_deframer_unit.sv @@
// Top level of the digitizer event stream deframer.
`default_nettype none

// Takes one 16-bit stream word per cycle while ready is high and splits the
// stream into digitizer events (8-word header, then a DPP or waveform body).
// Each accepted word is parsed in the cycle it is taken and its result, if
// any, goes to the output register, or to the skid register while the output
// register is stalled. A two-entry result buffer (output plus skid register)
// lets one more result in while a result is stalled; ready drops only when
// both entries are full, and ready never depends combinationally on the
// result side. No clearing pass is needed after reset.
module digitizer_event_stream_deframer_unit import desd_pkg::*; (
  input logic        clk,
  input logic        rst,
  desd_in_if.sink    stream,
  desd_out_if.source result
);

  logic step;
  logic res_valid;
  rec_t res;
  logic space;
  rec_t out_rec;

  assign stream.ready = space;
  assign step         = stream.valid && space;

  desd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .word      (stream.stream_word),
    .res_valid (res_valid),
    .res       (res)
  );

  desd_result_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_rec  (res),
    .space     (space),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_rec   (out_rec)
  );

  assign result.kind          = out_rec.kind;
  assign result.channel       = out_rec.channel;
  assign result.event_kind    = out_rec.event_kind;
  assign result.macro_number  = out_rec.macro_number;
  assign result.event_number  = out_rec.event_number;
  assign result.coarse_time   = out_rec.coarse_time;
  assign result.extended_time = out_rec.extended_time;
  assign result.fine_time     = out_rec.fine_time;
  assign result.short_charge  = out_rec.short_charge;
  assign result.long_charge   = out_rec.long_charge;
  assign result.sample_value  = out_rec.sample_value;
  assign result.last          = out_rec.last;

endmodule

`default_nettype wire
